### src/u8nl_pkg.sv
package u8nl_pkg;

  localparam int unsigned UNITS_W = 13;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [POS_W-1:0]   POS_LIMIT     = 14'd16383;
  localparam logic [UNITS_W-1:0] MAX_UNITS_RST = 13'd4000;

  // register indexes
  localparam logic REG_MAX_UNITS = 1'b0;

  // result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] LEAD_ASCII_END = 8'h80;
  localparam logic [7:0] LEAD_WIDE      = 8'hF0;
  localparam logic [7:0] MASK_E0 = 8'hE0;
  localparam logic [7:0] MASK_F0 = 8'hF0;
  localparam logic [7:0] MASK_F8 = 8'hF8;
  localparam logic [7:0] PAT_C0  = 8'hC0;
  localparam logic [7:0] PAT_E0  = 8'hE0;
  localparam logic [7:0] PAT_F0  = 8'hF0;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  kept_length;
    logic              last_result;
  } result_t;

  // up to two results per byte; second valid only together with first
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic logic [1:0] follow_bytes(input logic [7:0] lead);
    logic [1:0] n;
    n = 2'd0;
    if (lead < LEAD_ASCII_END) n = 2'd0;
    else if ((lead & MASK_E0) == PAT_C0) n = 2'd1;
    else if ((lead & MASK_F0) == PAT_E0) n = 2'd2;
    else if ((lead & MASK_F8) == PAT_F0) n = 2'd3;
    return n;
  endfunction

endpackage

### src/u8nl_core.sv
module u8nl_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [u8nl_pkg::BYTE_W-1:0]   text_byte,
  input  logic                          last_byte,
  input  logic [u8nl_pkg::UNITS_W-1:0]  max_units,
  output u8nl_pkg::push_t               push
);

  logic [u8nl_pkg::UNITS_W-1:0] unit_count_r, unit_count_nxt;
  logic [u8nl_pkg::POS_W-1:0]   out_count_r, out_count_nxt;
  logic [u8nl_pkg::POS_W-1:0]   trim_length_r, trim_length_nxt;
  logic [1:0]                   cont_left_r, cont_left_nxt;
  logic                         skip_lf_r, skip_lf_nxt;
  logic                         stopped_r, stopped_nxt;

  logic                         drop;
  logic                         full;
  logic                         emit;
  logic [7:0]                   emit_byte;
  logic [u8nl_pkg::UNITS_W:0]   unit_sum;
  logic [1:0]                   cost;
  u8nl_pkg::result_t            kept_res;
  u8nl_pkg::result_t            end_res;

  always_comb begin
    drop = (text_byte == u8nl_pkg::CH_NUL) ||
           (skip_lf_r && text_byte == u8nl_pkg::CH_LF);
    full = (out_count_r >= u8nl_pkg::POS_LIMIT);
    cost = (text_byte >= u8nl_pkg::LEAD_WIDE) ? 2'd2 : 2'd1;
    if (text_byte == u8nl_pkg::CH_CR) cost = 2'd1;
    unit_sum = {1'b0, unit_count_r} + {{(u8nl_pkg::UNITS_W-1){1'b0}}, cost};

    unit_count_nxt  = unit_count_r;
    out_count_nxt   = out_count_r;
    trim_length_nxt = trim_length_r;
    cont_left_nxt   = cont_left_r;
    skip_lf_nxt     = skip_lf_r;
    stopped_nxt     = stopped_r;
    emit            = 1'b0;
    emit_byte       = text_byte;

    if (text_byte != u8nl_pkg::CH_NUL) skip_lf_nxt = 1'b0;

    if (!drop && !stopped_r) begin
      if (cont_left_r != 2'd0) begin
        if (full) begin
          stopped_nxt   = 1'b1;
          cont_left_nxt = 2'd0;
        end else begin
          emit          = 1'b1;
          cont_left_nxt = cont_left_r - 2'd1;
        end
      end else if (unit_sum > {1'b0, max_units} || full) begin
        stopped_nxt   = 1'b1;
        cont_left_nxt = 2'd0;
      end else begin
        emit           = 1'b1;
        unit_count_nxt = unit_sum[u8nl_pkg::UNITS_W-1:0];
        if (text_byte == u8nl_pkg::CH_CR) begin
          emit_byte   = u8nl_pkg::CH_LF;
          skip_lf_nxt = 1'b1;
        end else begin
          cont_left_nxt = u8nl_pkg::follow_bytes(text_byte);
        end
      end
    end

    if (emit) begin
      out_count_nxt = out_count_r + 14'd1;
      if (emit_byte != u8nl_pkg::CH_LF && emit_byte != u8nl_pkg::CH_SPACE &&
          emit_byte != u8nl_pkg::CH_TAB)
        trim_length_nxt = out_count_r + 14'd1;
    end

    kept_res.kind        = u8nl_pkg::KIND_BYTE;
    kept_res.out_byte    = emit_byte;
    kept_res.position    = out_count_r;
    kept_res.kept_length = '0;
    kept_res.last_result = 1'b0;

    end_res.kind        = u8nl_pkg::KIND_END;
    end_res.out_byte    = '0;
    end_res.position    = '0;
    end_res.kept_length = trim_length_nxt;
    end_res.last_result = 1'b1;

    push.v0 = step && (emit || last_byte);
    push.v1 = step && emit && last_byte;
    push.r0 = emit ? kept_res : end_res;
    push.r1 = end_res;

    // end of text puts every counter back to its start
    if (last_byte) begin
      unit_count_nxt  = '0;
      out_count_nxt   = '0;
      trim_length_nxt = '0;
      cont_left_nxt   = 2'd0;
      skip_lf_nxt     = 1'b0;
      stopped_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r  <= '0;
      out_count_r   <= '0;
      trim_length_r <= '0;
      cont_left_r   <= 2'd0;
      skip_lf_r     <= 1'b0;
      stopped_r     <= 1'b0;
    end else if (step) begin
      unit_count_r  <= unit_count_nxt;
      out_count_r   <= out_count_nxt;
      trim_length_r <= trim_length_nxt;
      cont_left_r   <= cont_left_nxt;
      skip_lf_r     <= skip_lf_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

endmodule

### src/u8nl_fifo.sv
module u8nl_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  u8nl_pkg::push_t                push,
  input  logic                           pop,
  output u8nl_pkg::result_t              head,
  output logic                           not_empty,
  output logic [u8nl_pkg::FIFO_CW-1:0]   count
);

  u8nl_pkg::result_t                  mem_r [u8nl_pkg::FIFO_DEPTH];
  logic [u8nl_pkg::FIFO_AW-1:0]       wptr_r, wptr_nxt;
  logic [u8nl_pkg::FIFO_AW-1:0]       rptr_r, rptr_nxt;
  logic [u8nl_pkg::FIFO_CW-1:0]       count_r, count_nxt;
  logic [u8nl_pkg::FIFO_CW-1:0]       npush;
  logic [u8nl_pkg::FIFO_AW-1:0]       wptr_inc;

  always_comb begin
    npush    = {{(u8nl_pkg::FIFO_CW-1){1'b0}}, push.v0} +
               {{(u8nl_pkg::FIFO_CW-1){1'b0}}, push.v1};
    wptr_inc = wptr_r + {{(u8nl_pkg::FIFO_AW-1){1'b0}}, 1'b1};
    wptr_nxt = wptr_r + npush[u8nl_pkg::FIFO_AW-1:0];
    rptr_nxt = pop ? rptr_r + {{(u8nl_pkg::FIFO_AW-1){1'b0}}, 1'b1} : rptr_r;
    count_nxt = count_r + npush - {{(u8nl_pkg::FIFO_CW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wptr_r] <= push.r0;
    if (push.v1) mem_r[wptr_inc] <= push.r1;
  end

  assign head      = mem_r[rptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

### src/utf8_newline_normalize_truncate.sv
// Normalizes one UTF-8 text per frame: NULs are dropped, CR and CRLF become LF,
// and bytes are kept until the UTF-16 unit cap in max_units (register 0) is hit.
// Each kept byte comes out with its position; the frame's last byte also yields
// an end word carrying the trimmed length. One byte is accepted per cycle,
// set by a single registered pass through the normalizer; results pass from
// the input register through a four-word result FIFO that moves one word per
// cycle while out_tready is high, so a last byte that also keeps a byte yields
// two words. Input is held off only while that FIFO holds more than two words.
module utf8_newline_normalize_truncate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [21:8] position, [35:22] kept_length
  output logic [0:0]  out_tuser,  // [0] kind
  output logic        out_tlast,  // last_result
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [u8nl_pkg::UNITS_W-1:0] max_units_r;
  logic [7:0]                   in_byte_r;
  logic                         in_last_r;
  logic                         in_valid_r, in_valid_nxt;
  logic                         step;
  logic                         in_acc;
  logic                         pop;
  u8nl_pkg::push_t              push;
  u8nl_pkg::result_t            head;
  logic                         not_empty;
  logic [u8nl_pkg::FIFO_CW-1:0] fifo_count;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == u8nl_pkg::REG_MAX_UNITS) ?
                      {{(32-u8nl_pkg::UNITS_W){1'b0}}, max_units_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= u8nl_pkg::MAX_UNITS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == u8nl_pkg::REG_MAX_UNITS) begin
      max_units_r <= cfg_pwdata[u8nl_pkg::UNITS_W-1:0];
    end
  end

  // room for two words keeps every byte's results together
  assign step      = in_valid_r && (fifo_count <= 3'd2);
  assign in_tready = !in_valid_r || step;
  assign in_acc    = in_tvalid && in_tready;
  assign in_valid_nxt = in_acc ? 1'b1 : (step ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else        in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  u8nl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (in_byte_r),
    .last_byte (in_last_r),
    .max_units (max_units_r),
    .push      (push)
  );

  assign pop = not_empty && out_tready;

  u8nl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (fifo_count)
  );

  assign out_tvalid   = not_empty;
  assign out_tdata    = {4'd0, head.kept_length, head.position, head.out_byte};
  assign out_tuser[0] = head.kind;
  assign out_tlast    = head.last_result;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= 3'd4)
    else $error("result fifo overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0)
    else $error("second result pushed alone");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !step) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_last_r)))
    else $error("pending byte lost");

  a_push_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> step)
    else $error("result pushed without a byte");

endmodule

### tb/u8nl_checker.sv
module u8nl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CAP_ADDR = {u8nl_pkg::REG_MAX_UNITS, 2'b00};

  logic [u8nl_pkg::UNITS_W-1:0] unit_cap;
  logic [u8nl_pkg::UNITS_W-1:0] units_used;
  logic [u8nl_pkg::POS_W-1:0]   bytes_out;
  logic [u8nl_pkg::POS_W-1:0]   trimmed_len;
  logic [1:0]                   seq_left;
  logic                         lf_skip;
  logic                         halted;
  u8nl_pkg::result_t            due_words[$];
  int                           mismatches = 0;

  assign fail_count = mismatches;

  function automatic void queue_word(input u8nl_pkg::result_t w);
    due_words.insert(due_words.size(), w);
  endfunction

  function automatic logic [1:0] seq_tail(input logic [7:0] b);
    if (b[7] == 1'b0) return 2'd0;
    if (b[7:5] == 3'b110) return 2'd1;
    if (b[7:4] == 4'b1110) return 2'd2;
    if (b[7:3] == 5'b11110) return 2'd3;
    return 2'd0;
  endfunction

  function automatic void clear_text();
    units_used  = '0;
    bytes_out   = '0;
    trimmed_len = '0;
    seq_left    = '0;
    lf_skip     = 1'b0;
    halted      = 1'b0;
  endfunction

  function automatic void halt_text();
    halted   = 1'b1;
    seq_left = '0;
  endfunction

  // appends a kept byte; a full position range halts the text instead
  function automatic bit store_byte(input logic [7:0] b);
    u8nl_pkg::result_t w;
    if (bytes_out >= u8nl_pkg::POS_LIMIT) begin
      halt_text();
      return 1'b0;
    end
    w.kind        = u8nl_pkg::KIND_BYTE;
    w.out_byte    = b;
    w.position    = bytes_out;
    w.kept_length = '0;
    w.last_result = 1'b0;
    queue_word(w);
    bytes_out = bytes_out + 1'b1;
    if (b != u8nl_pkg::CH_LF && b != u8nl_pkg::CH_SPACE && b != u8nl_pkg::CH_TAB)
      trimmed_len = bytes_out;
    return 1'b1;
  endfunction

  function automatic void normalize_byte(input logic [7:0] b, input logic last);
    bit                drop;
    int unsigned       cost;
    u8nl_pkg::result_t w;
    drop = 1'b0;
    if (b == u8nl_pkg::CH_NUL) begin
      drop = 1'b1;
    end else if (lf_skip) begin
      lf_skip = 1'b0;
      if (b == u8nl_pkg::CH_LF) drop = 1'b1;
    end
    if (!drop && !halted) begin
      if (seq_left != 0) begin
        if (store_byte(b)) seq_left = seq_left - 1'b1;
      end else if (b == u8nl_pkg::CH_CR) begin
        if (units_used + 1 > unit_cap) begin
          halt_text();
        end else if (store_byte(u8nl_pkg::CH_LF)) begin
          units_used = units_used + 1'b1;
          lf_skip = 1'b1;
        end
      end else begin
        cost = (b >= u8nl_pkg::LEAD_WIDE) ? 2 : 1;
        if (units_used + cost > unit_cap) begin
          halt_text();
        end else if (store_byte(b)) begin
          units_used = units_used + cost[u8nl_pkg::UNITS_W-1:0];
          seq_left = seq_tail(b);
        end
      end
    end
    if (last) begin
      w.kind        = u8nl_pkg::KIND_END;
      w.out_byte    = '0;
      w.position    = '0;
      w.kept_length = trimmed_len;
      w.last_result = 1'b1;
      queue_word(w);
      clear_text();
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    u8nl_pkg::result_t want;
    if (!rst_n) begin
      unit_cap = u8nl_pkg::MAX_UNITS_RST;
      clear_text();
      due_words.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == CAP_ADDR) begin
        if (cfg_pwrite) unit_cap = cfg_pwdata[u8nl_pkg::UNITS_W-1:0];
        else check_field("max_units", unit_cap, cfg_prdata);
      end
      if (in_tvalid && in_tready) normalize_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (due_words.size() == 0) begin
          $error("unexpected result word: tuser %0h tdata %0h tlast %0b",
                 out_tuser, out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          check_field("kind", want.kind, out_tuser[0]);
          check_field("out_byte", want.out_byte, out_tdata[7:0]);
          check_field("position", want.position, out_tdata[21:8]);
          check_field("kept_length", want.kept_length, out_tdata[35:22]);
          check_field("last_result", want.last_result, out_tlast);
        end
      end
    end
    pending <= due_words.size();
  end

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CAP_ADDR    = {u8nl_pkg::REG_MAX_UNITS, 2'b00};
  localparam int         TOTAL_BYTES = 1600;
  localparam int         QUIET_TAIL  = 150;
  localparam int         PHASE_BYTES = 200;
  localparam int         HOLD_CYCLES = 300;
  localparam int         STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int         fail_count;
  int         pending;
  int         sent = 0;
  bit         tx_idle = 1'b1;
  bit         rx_stalls = 1'b1;
  bit         quiet = 1'b0;
  bit         long_hold = 1'b0;
  logic [7:0] text_q[$];

  utf8_newline_normalize_truncate DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  u8nl_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  task automatic cfg_access(input bit wr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_cap(input int unsigned units);
    drain_results();
    // end words may still be in flight behind the last counted one
    repeat (4) @(posedge clk);
    cfg_access(1'b1, units);
    cfg_access(1'b0, '0);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit last);
    if (tx_idle && !quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // mostly well-formed utf-8 with line breaks and blanks, some noise
  task automatic compose_text(input int tokens);
    int tail;
    text_q.delete();
    repeat (tokens) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: add_byte(8'($urandom_range(8'h21, 8'h7E)));
        6, 7: add_byte($urandom_range(0, 1) ? u8nl_pkg::CH_SPACE : u8nl_pkg::CH_TAB);
        8: add_byte(u8nl_pkg::CH_LF);
        9: add_byte(u8nl_pkg::CH_CR);
        10: begin
          add_byte(u8nl_pkg::CH_CR);
          add_byte(u8nl_pkg::CH_LF);
        end
        11: add_byte(u8nl_pkg::CH_NUL);
        12: begin
          add_byte(8'($urandom_range(8'hC2, 8'hDF)));
          add_byte(rand_cont());
        end
        13: begin
          add_byte(8'($urandom_range(8'hE0, 8'hEF)));
          repeat (2) add_byte(rand_cont());
        end
        14: begin
          add_byte(8'($urandom_range(8'hF0, 8'hF4)));
          repeat (3) add_byte(rand_cont());
        end
        15: add_byte($urandom_range(0, 1) ? rand_cont()
                                          : 8'($urandom_range(8'hF8, 8'hFF)));
        16: begin
          add_byte(8'($urandom_range(8'hC0, 8'hF7)));
          tail = $urandom_range(0, 1);
          repeat (tail) add_byte(rand_cont());
        end
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin : receiver
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && rx_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("utf8_newline_normalize_truncate verification failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_end;
    int tokens;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset cap: nul drop, cr and crlf with a nul inside, multibyte, strays, trim
    text_q = '{u8nl_pkg::CH_NUL, 8'h41, u8nl_pkg::CH_CR, u8nl_pkg::CH_NUL,
               u8nl_pkg::CH_LF, u8nl_pkg::CH_CR, u8nl_pkg::CH_CR, 8'hC3, 8'hA9,
               8'hE2, u8nl_pkg::CH_CR, u8nl_pkg::CH_SPACE, 8'hF0, 8'h9F, 8'h98,
               8'h80, 8'h80, 8'hFF, 8'h7F, u8nl_pkg::CH_TAB, u8nl_pkg::CH_SPACE,
               u8nl_pkg::CH_LF};
    send_text();
    text_q = '{u8nl_pkg::CH_NUL, u8nl_pkg::CH_NUL};
    send_text();
    text_q = '{8'hE2};
    send_text();
    // cap filled exactly, then a cr stops the text
    set_cap(1);
    text_q = '{8'h41, u8nl_pkg::CH_CR, 8'h42};
    send_text();
    // wide lead fills the cap, the next lead stops the text
    set_cap(2);
    text_q = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'h41};
    send_text();

    phase = 0;
    while (sent < TOTAL_BYTES) begin
      if (phase == 0)
        set_cap(5000);
      else if ($urandom_range(0, 2) == 0)
        set_cap($urandom_range(13, 5000));
      else
        set_cap($urandom_range(1, 12));
      tx_idle   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      if (phase == 2) begin
        // receiver stops for a long stretch while the sender keeps pushing
        tx_idle = 1'b0;
        long_hold = 1'b1;
        compose_text(80);
        send_text();
      end
      phase_end = sent + PHASE_BYTES;
      while (sent < phase_end && sent < TOTAL_BYTES) begin
        quiet = sent >= TOTAL_BYTES - QUIET_TAIL;
        tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                             : $urandom_range(1, 12);
        compose_text(tokens);
        send_text();
        if (!quiet && $urandom_range(0, 15) == 0) drain_results();
      end
      phase++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("utf8_newline_normalize_truncate verification clean");
    else
      $display("utf8_newline_normalize_truncate verification failed");
    $finish;
  end

endmodule
